@@ src/trm_pkg.sv @@
`timescale 1ns / 1ps

package trm_pkg;

    // Fixed field widths of the instruction and result items.
    localparam int OP_W        = 3;
    localparam int IDX_FIELD_W = 4;
    localparam int DATA_W      = 32;
    localparam int NEXT_PC_W   = 16;

    // Defaults for the top-level parameters.
    localparam int NUM_REGS_DEFAULT = 10;
    localparam int PC_BITS_DEFAULT  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_SET    = 3'd0,
        OP_SHOW   = 3'd1,
        OP_ADD    = 3'd2,
        OP_MUL    = 3'd3,
        OP_BRANCH = 3'd4,
        OP_HALT   = 3'd5
    } opcode_t;

    // Register file write request from the execute unit.
    typedef struct packed {
        logic                   we;
        logic [IDX_FIELD_W-1:0] idx;
        logic [DATA_W-1:0]      data;
    } wb_req_t;

endpackage

@@ src/toy_register_machine_execute.sv @@
`timescale 1ns / 1ps

// Channel    Direction  Handshake                  Payload
// instr      in         instr_valid / instr_ready  opcode, reg_index, immediate
// result     out        result_valid / result_ready show_valid, show_value,
//                                                   next_pc, halted
//
// Each instruction is captured in an input register and executed once the
// output register is free or being emptied, and its result is written to
// the output register. Throughput is one instruction per cycle while results
// are taken. A result passes the input and then the output register before
// it can leave. The rate is set by the single execute pass (register file
// read, one 32x32 multiply or add, writeback) between the two registers.
// Reset clears the register file, program counter, halt flag and all valid
// bits. A stalled result holds the input register, and instr_ready then
// drops once that register is full.

module toy_register_machine_execute
    import trm_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEFAULT,
    parameter int PC_BITS  = PC_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          instr_valid,
    output logic                          instr_ready,
    input  logic [OP_W-1:0]               opcode,
    input  logic [IDX_FIELD_W-1:0]        reg_index,
    input  logic signed [DATA_W-1:0]      immediate,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          show_valid,
    output logic signed [DATA_W-1:0]      show_value,
    output logic [NEXT_PC_W-1:0]          next_pc,
    output logic                          halted
);

    // Input register: holds one accepted instruction until it executes.
    logic                   s1_valid_reg;
    logic [OP_W-1:0]        s1_opcode_reg;
    logic [IDX_FIELD_W-1:0] s1_reg_index_reg;
    logic [DATA_W-1:0]      s1_immediate_reg;

    // Architectural state besides the register file.
    logic [PC_BITS-1:0]     pc_reg;
    logic                   halt_reg;

    // Output register.
    logic                   result_valid_reg;
    logic                   show_valid_reg;
    logic [DATA_W-1:0]      show_value_reg;
    logic [NEXT_PC_W-1:0]   next_pc_reg;
    logic                   halted_reg;

    // Execute unit outputs.
    wb_req_t                wb_raw;
    wb_req_t                wb;
    logic [DATA_W-1:0]      rd_data;
    logic [PC_BITS-1:0]     pc_next;
    logic                   halt_next;
    logic                   exe_show_valid;
    logic [DATA_W-1:0]      exe_show_value;
    logic [PC_BITS+NEXT_PC_W-1:0] pc_next_ext;

    logic                   s1_fire;
    logic                   in_fire;

    // The held instruction executes whenever the output register is free
    // or is being emptied in this cycle. State and the result update on the
    // same edge, so the next instruction always sees this one's effects.
    assign s1_fire     = s1_valid_reg && (!result_valid_reg || result_ready);
    assign instr_ready = !s1_valid_reg || s1_fire;
    assign in_fire     = instr_valid && instr_ready;

    trm_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (s1_reg_index_reg),
        .rd_data (rd_data),
        .wb      (wb)
    );

    trm_alu #(
        .PC_BITS (PC_BITS)
    ) u_alu (
        .opcode     (s1_opcode_reg),
        .reg_index  (s1_reg_index_reg),
        .imm        (s1_immediate_reg),
        .rd_data    (rd_data),
        .pc         (pc_reg),
        .halt       (halt_reg),
        .wb         (wb_raw),
        .pc_next    (pc_next),
        .halt_next  (halt_next),
        .show_valid (exe_show_valid),
        .show_value (exe_show_value)
    );

    // Writes only land when the instruction actually executes.
    always_comb
    begin
        wb    = wb_raw;
        wb.we = wb_raw.we && s1_fire;
    end

    // The reported counter is the low 16 bits, zero-extended for short PCs.
    assign pc_next_ext = {{NEXT_PC_W{1'b0}}, pc_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            pc_reg           <= '0;
            halt_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            show_valid_reg   <= 1'b0;
            next_pc_reg      <= '0;
            halted_reg       <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                pc_reg           <= pc_next;
                halt_reg         <= halt_next;
                result_valid_reg <= 1'b1;
                show_valid_reg   <= exe_show_valid;
                next_pc_reg      <= pc_next_ext[NEXT_PC_W-1:0];
                halted_reg       <= halt_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_opcode_reg    <= opcode;
            s1_reg_index_reg <= reg_index;
            s1_immediate_reg <= $unsigned(immediate);
        end
        if (s1_fire)
        begin
            show_value_reg <= exe_show_value;
        end
    end

    assign result_valid = result_valid_reg;
    assign show_valid   = show_valid_reg;
    assign show_value   = $signed(show_value_reg);
    assign next_pc      = next_pc_reg;
    assign halted       = halted_reg;

endmodule

@@ src/trm_regfile.sv @@
`timescale 1ns / 1ps

module trm_regfile
    import trm_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IDX_FIELD_W-1:0] rd_idx,
    output logic [DATA_W-1:0]      rd_data,
    input  wb_req_t                wb
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [DATA_W-1:0] regs_reg [NUM_REGS];
    logic              rd_in_range;
    logic              wr_in_range;

    // Indexes at or above the register count read as zero and drop writes.
    assign rd_in_range = ({1'b0, rd_idx} < (IDX_FIELD_W+1)'(NUM_REGS));
    assign wr_in_range = ({1'b0, wb.idx} < (IDX_FIELD_W+1)'(NUM_REGS));

    assign rd_data = rd_in_range ? regs_reg[rd_idx[IDX_W-1:0]] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (wb.we && wr_in_range)
        begin
            regs_reg[wb.idx[IDX_W-1:0]] <= wb.data;
        end
    end

endmodule

@@ src/trm_alu.sv @@
`timescale 1ns / 1ps

module trm_alu
    import trm_pkg::*;
#(
    parameter int PC_BITS = PC_BITS_DEFAULT
)
(
    input  logic [OP_W-1:0]        opcode,
    input  logic [IDX_FIELD_W-1:0] reg_index,
    input  logic [DATA_W-1:0]      imm,
    input  logic [DATA_W-1:0]      rd_data,
    input  logic [PC_BITS-1:0]     pc,
    input  logic                   halt,
    output wb_req_t                wb,
    output logic [PC_BITS-1:0]     pc_next,
    output logic                   halt_next,
    output logic                   show_valid,
    output logic [DATA_W-1:0]      show_value
);

    logic [DATA_W-1:0]  sum;
    logic [DATA_W-1:0]  prod;
    logic [PC_BITS-1:0] pc_inc;

    assign sum    = rd_data + imm;
    assign prod   = rd_data * imm;
    assign pc_inc = pc + PC_BITS'(1);

    always_comb
    begin
        wb.we      = 1'b0;
        wb.idx     = reg_index;
        wb.data    = imm;
        pc_next    = pc_inc;
        halt_next  = halt;
        show_valid = 1'b0;
        show_value = '0;
        if (halt)
        begin
            // A halted machine ignores the item entirely.
            pc_next = pc;
        end
        else
        begin
            case (opcode)
                OP_SET:
                begin
                    wb.we = 1'b1;
                end
                OP_SHOW:
                begin
                    show_valid = 1'b1;
                    show_value = rd_data;
                end
                OP_ADD:
                begin
                    wb.we   = 1'b1;
                    wb.data = sum;
                end
                OP_MUL:
                begin
                    wb.we   = 1'b1;
                    wb.data = prod;
                end
                OP_BRANCH:
                begin
                    if (rd_data != '0)
                    begin
                        pc_next = pc_inc + imm[PC_BITS-1:0];
                    end
                end
                OP_HALT:
                begin
                    halt_next = 1'b1;
                    pc_next   = pc;
                end
                default:
                begin
                    // Unused opcodes only advance the counter.
                end
            endcase
        end
    end

endmodule

@@ src/trm_checker.sv @@
`timescale 1ns / 1ps

module trm_checker
    import trm_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     instr_ready,
    input logic                     result_valid,
    input logic                     result_ready,
    input logic                     show_valid,
    input logic signed [DATA_W-1:0] show_value,
    input logic [NEXT_PC_W-1:0]     next_pc,
    input logic                     halted
);

    // Only a reset can clear the halt.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(halted))
        else $error("halted dropped without reset");

    // Once halted, the reported counter is frozen.
    a_halt_pc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (halted && $past(halted)) |-> $stable(next_pc))
        else $error("next_pc moved while halted");

    // A show result is never produced by a halted machine.
    a_show_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && show_valid) |-> !halted)
        else $error("show result reported while halted");

    // A stalled result keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(show_value) && $stable(show_valid)
             && $stable(next_pc) && $stable(halted)))
        else $error("stalled result changed");

    // With the output register empty, an instruction can always be taken.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> instr_ready)
        else $error("instr_ready low with no result waiting");

endmodule

bind toy_register_machine_execute trm_checker u_trm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .instr_ready  (instr_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .show_valid   (show_valid),
    .show_value   (show_value),
    .next_pc      (next_pc),
    .halted       (halted)
);

@@ tb/toy_register_machine_execute_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the execute stage of the toy register machine.
// A behavioral copy of the machine state (registers, program counter and
// halt flag) predicts one result for every instruction that the block
// accepts. Results are compared in order against those predictions.

module toy_register_machine_execute_tb;
    import trm_pkg::*;

    // The two opcodes that the machine does not define. They must behave as
    // a no-op that still advances the program counter.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int TAIL_ITEMS    = 100;
    localparam int REPORT_MAX    = 10;

    // One expected result, laid out in the same order as the output ports
    // so that a whole result can be compared in one step.
    typedef struct packed {
        logic                   show_valid;
        logic [DATA_W-1:0]      show_value;
        logic [NEXT_PC_W-1:0]   next_pc;
        logic                   halted;
    } machine_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       instr_valid = 1'b0;
    logic                       instr_ready;
    logic [OP_W-1:0]            opcode = '0;
    logic [IDX_FIELD_W-1:0]     reg_index = '0;
    logic signed [DATA_W-1:0]   immediate = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic                       show_valid;
    logic signed [DATA_W-1:0]   show_value;
    logic [NEXT_PC_W-1:0]       next_pc;
    logic                       halted;

    // Architectural state as the bench believes it to be.
    logic [DATA_W-1:0]          arch_regs [NUM_REGS_DEFAULT];
    logic [NEXT_PC_W-1:0]       arch_pc;
    logic                       arch_halted;

    // Results predicted but not yet seen at the output, oldest first.
    machine_result_t            pending_results [$];

    // When set, both the instruction sender and the result sink insert
    // random stall bursts.
    bit                         idle_on = 1'b0;

    int                         cycle_count = 0;
    int                         mismatches = 0;
    int                         results_checked = 0;
    int                         shows_predicted = 0;
    int                         branches_taken = 0;
    int                         ready_hold = 0;

    toy_register_machine_execute dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_ready  (instr_ready),
        .opcode       (opcode),
        .reg_index    (reg_index),
        .immediate    (immediate),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .show_valid   (show_valid),
        .show_value   (show_value),
        .next_pc      (next_pc),
        .halted       (halted)
    );

    always #10 clk = ~clk;

    // Watchdog. A correct run finishes far below this count even when every
    // item sees the longest sender gap and the longest result stall.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("toy_register_machine_execute test failed");
            $finish;
        end
    end

    // Result sink. While idling is enabled it occasionally drops ready for
    // a burst; otherwise it always takes the result.
    always @(posedge clk)
    begin
        if (idle_on && ready_hold > 0)
        begin
            ready_hold   <= ready_hold - 1;
            result_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            ready_hold   <= $urandom_range(1, 16) - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            ready_hold   <= 0;
            result_ready <= 1'b1;
        end
    end

    // Result checker. Values are sampled at the clock edge, before any
    // update that the edge causes, so the sample is the accepted result.
    always @(posedge clk)
    begin : result_check
        machine_result_t want;
        machine_result_t got;
        if (rst_n && result_valid && result_ready)
        begin
            got = {show_valid, show_value, next_pc, halted};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] result arrived with no instruction pending: %p",
                             $realtime, got);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display(
                            "[%0t] mismatch (exp/act): sv %0b/%0b val %h/%h pc %h/%h halt %0b/%0b",
                            $realtime, want.show_valid, got.show_valid,
                            want.show_value, got.show_value,
                            want.next_pc, got.next_pc, want.halted, got.halted);
                end
            end
        end
    end

    // Applies one instruction to the bench's copy of the machine and queues
    // the result that the block must produce for it. Registers beyond the
    // implemented count read as zero and ignore writes. Once halted, the
    // machine ignores everything and reports the halt address.
    function automatic void predict_execution(input logic [OP_W-1:0] op,
                                              input logic [IDX_FIELD_W-1:0] idx,
                                              input logic [DATA_W-1:0] imm);
        machine_result_t      res;
        logic [DATA_W-1:0]    operand;
        logic [DATA_W-1:0]    wdata;
        logic                 do_write;
        logic [NEXT_PC_W-1:0] npc;
        res      = '0;
        do_write = 1'b0;
        wdata    = '0;
        operand  = (idx < NUM_REGS_DEFAULT) ? arch_regs[idx] : '0;
        if (!arch_halted)
        begin
            npc = arch_pc + 1'b1;
            case (op)
                OP_SET:
                begin
                    wdata    = imm;
                    do_write = 1'b1;
                end
                OP_SHOW:
                begin
                    res.show_valid = 1'b1;
                    res.show_value = operand;
                    shows_predicted++;
                end
                OP_ADD:
                begin
                    wdata    = operand + imm;
                    do_write = 1'b1;
                end
                OP_MUL:
                begin
                    // Only the low 32 bits of the product survive.
                    wdata    = operand * imm;
                    do_write = 1'b1;
                end
                OP_BRANCH:
                begin
                    if (operand != '0)
                    begin
                        npc = arch_pc + 1'b1 + imm[NEXT_PC_W-1:0];
                        branches_taken++;
                    end
                end
                OP_HALT:
                begin
                    arch_halted = 1'b1;
                    npc         = arch_pc;
                end
                default:
                begin
                end
            endcase
            if (do_write && idx < NUM_REGS_DEFAULT)
                arch_regs[idx] = wdata;
            arch_pc = npc;
        end
        res.next_pc = arch_pc;
        res.halted  = arch_halted;
        pending_results.push_back(res);
    endfunction

    // Presents one instruction and waits until the block takes it. It is
    // entered at a rising edge; valid stays high across back-to-back items
    // and is lowered only for an idle burst.
    task automatic send_instr(input logic [OP_W-1:0] op,
                              input logic [IDX_FIELD_W-1:0] idx,
                              input logic [DATA_W-1:0] imm);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            instr_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_valid <= 1'b1;
        opcode      <= op;
        reg_index   <= idx;
        immediate   <= imm;
        @(posedge clk);
        while (!instr_ready)
            @(posedge clk);
        predict_execution(op, idx, imm);
    endtask

    // Immediates mix small signed values, which keep branches short and
    // products readable, with regular extremes and, most often, full random words.
    function automatic logic [DATA_W-1:0] random_immediate();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 16) - 8;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'h0000_0001;
                    default: v = '0;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // A single unstructured instruction: any opcode except halt, any index
    // including the unimplemented ones, any immediate.
    task automatic send_random_instr();
        logic [OP_W-1:0] op;
        op = OP_W'($urandom_range(0, 7));
        if (op == OP_HALT)
            op = OP_SHOW;
        send_instr(op, IDX_FIELD_W'($urandom_range(0, 15)), random_immediate());
    endtask

    // A short program fragment: load a register, work on it for a few
    // instructions, then read it back. Returns the number of items sent.
    task automatic send_snippet(output int count);
        logic [IDX_FIELD_W-1:0] idx;
        logic [OP_W-1:0]        op;
        int                     len;
        idx = IDX_FIELD_W'($urandom_range(0, NUM_REGS_DEFAULT - 1));
        len = $urandom_range(1, 6);
        send_instr(OP_SET, idx, random_immediate());
        repeat (len)
        begin
            case ($urandom_range(0, 3))
                0: op = OP_ADD;
                1: op = OP_MUL;
                2: op = OP_SHOW;
                default: op = OP_BRANCH;
            endcase
            send_instr(op, idx, random_immediate());
        end
        send_instr(OP_SHOW, idx, $urandom());
        count = len + 2;
    endtask

    // Loads at both ends of the signed range and reads of an untouched
    // register, which must still hold its reset value.
    task automatic test_set_and_show();
        send_instr(OP_SHOW, 4'd5, 32'h0);
        send_instr(OP_SET, 4'd0, 32'h7FFF_FFFF);
        send_instr(OP_SHOW, 4'd0, 32'h0);
        send_instr(OP_SET, 4'd9, 32'h8000_0000);
        send_instr(OP_SHOW, 4'd9, 32'hFFFF_FFFF);
    endtask

    // Add and multiply must wrap modulo 2^32.
    task automatic test_arithmetic_wrap();
        send_instr(OP_ADD, 4'd0, 32'h0000_0001);
        send_instr(OP_SHOW, 4'd0, 32'h0);
        send_instr(OP_MUL, 4'd9, 32'hFFFF_FFFF);
        send_instr(OP_SHOW, 4'd9, 32'h0);
        send_instr(OP_SET, 4'd3, 32'hFFFF_FFFF);
        send_instr(OP_MUL, 4'd3, 32'hFFFF_FFFF);
        send_instr(OP_SHOW, 4'd3, 32'h0);
    endtask

    // Branches on a zero register fall through; taken branches cover a
    // self-loop and offsets whose upper bits must be dropped.
    task automatic test_branches();
        send_instr(OP_BRANCH, 4'd5, 32'h0000_0100);
        send_instr(OP_BRANCH, 4'd3, 32'hFFFF_FFFF);
        send_instr(OP_BRANCH, 4'd3, 32'h7FFF_FFFF);
        send_instr(OP_BRANCH, 4'd3, 32'h8000_0000);
    endtask

    // Register indexes past the implemented count and the spare opcodes.
    task automatic test_odd_encodings();
        send_instr(OP_SET, 4'd15, 32'hDEAD_BEEF);
        send_instr(OP_SHOW, 4'd15, 32'h0);
        send_instr(OP_ADD, 4'd10, 32'h0000_0005);
        send_instr(OP_BRANCH, 4'd12, 32'h0000_0010);
        send_instr(OP_SPARE_A, 4'd1, 32'h5555_5555);
        send_instr(OP_SPARE_B, 4'd14, 32'hAAAA_AAAA);
    endtask

    // Mostly well-formed fragments with random content, some raw noise.
    // Idling is switched on and off in stretches so that bursts land in
    // every phase of the pipeline and some stretches run at full rate.
    task automatic test_random_programs(input int n_items, input bit allow_idle);
        int sent;
        int chunk;
        int next_switch;
        sent        = 0;
        next_switch = 0;
        while (sent < n_items)
        begin
            if (sent >= next_switch)
            begin
                idle_on     = allow_idle && ($urandom_range(0, 3) != 0);
                next_switch = sent + $urandom_range(50, 200);
            end
            if ($urandom_range(0, 9) < 7)
            begin
                send_snippet(chunk);
                sent += chunk;
            end
            else
            begin
                send_random_instr();
                sent++;
            end
        end
    endtask

    // Halt freezes the machine: later instructions, a second halt among
    // them, change nothing and report the halt address.
    task automatic test_halt();
        send_instr(OP_SET, 4'd2, 32'h0000_0005);
        send_instr(OP_HALT, 4'd0, 32'h0000_1234);
        send_instr(OP_SHOW, 4'd2, 32'h0);
        send_instr(OP_SET, 4'd2, 32'h0000_0000);
        send_instr(OP_BRANCH, 4'd2, 32'h0000_0040);
        send_instr(OP_SPARE_B, 4'd7, 32'h0);
        send_instr(OP_HALT, 4'd1, 32'h0);
        repeat (6)
            send_random_instr();
    endtask

    initial
    begin
        for (int i = 0; i < NUM_REGS_DEFAULT; i++)
            arch_regs[i] = '0;
        arch_pc     = '0;
        arch_halted = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed part runs at full rate; stalls start with the
        // random programs.
        test_set_and_show();
        test_arithmetic_wrap();
        test_branches();
        test_odd_encodings();
        test_random_programs(RANDOM_ITEMS, 1'b1);

        // The last part of the run has no idling on either side.
        idle_on = 1'b0;
        test_random_programs(TAIL_ITEMS, 1'b0);
        test_halt();
        instr_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // Leave room for any stray result beyond the pipeline latency.
        repeat (10) @(posedge clk);

        $display("Checked %0d results: %0d register reads and %0d taken branches,",
                 results_checked, shows_predicted, branches_taken);
        $display("including wraparound, unused encodings and items after a halt.");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("toy_register_machine_execute test passed");
        else
            $display("toy_register_machine_execute test failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/trm_pkg.sv
src/trm_regfile.sv
src/trm_alu.sv
src/toy_register_machine_execute.sv
src/trm_checker.sv
tb/toy_register_machine_execute_tb.sv
